/* src/pvsc_pkg.sv */
// ----------------------------------------------------------------------------
// pvsc_pkg
// Shared types and constants of the pneumatic valve setpoint control core.
// ----------------------------------------------------------------------------
package pvsc_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OPND,
    S_MUL,
    S_DIV,
    S_FIN,
    S_CHK,
    S_EVAL
  } state_t;

  // arithmetic jobs, run in this order
  localparam logic [1:0] OP_PUSER  = 2'd0;
  localparam logic [1:0] OP_SP     = 2'd1;
  localparam logic [1:0] OP_INFM   = 2'd2;
  localparam logic [1:0] OP_REFM   = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_MIN_P   = 3'd0;
  localparam logic [2:0] REG_MAX_P   = 3'd1;
  localparam logic [2:0] REG_SAFETY  = 3'd2;
  localparam logic [2:0] REG_TIMEOUT = 3'd3;
  localparam logic [2:0] REG_DMARGIN = 3'd4;
  localparam logic [2:0] REG_USER_MIN = 3'd5;
  localparam logic [2:0] REG_USER_MAX = 3'd6;

  // valve commands
  localparam logic [1:0] VALVE_OFF = 2'd0;
  localparam logic [1:0] VALVE_INF = 2'd1;
  localparam logic [1:0] VALVE_DEF = 2'd2;

  localparam int DIV_STEPS = 33;   // quotient bits
  localparam logic [5:0] DIV_LAST = 6'(DIV_STEPS - 1);

  // |x|/10 and |x|/20 for |x| < 2^16: multiply by ceil(2^19/10), then shift
  localparam logic signed [16:0] RECIP_TEN    = 17'sd52429;
  localparam int                 REFILL_SHIFT = 19;
  localparam int                 INF_SHIFT    = 20;

  localparam logic signed [34:0] SAT_HI = 35'sd32767;
  localparam logic signed [34:0] SAT_LO = -35'sd32768;

endpackage

/* src/pneumatic_valve_setpoint_control_core.sv */
// ----------------------------------------------------------------------------
// pneumatic_valve_setpoint_control_core
// Bang-bang pressure control step with hysteresis, timeouts and refill.
// Two range divisions share one restoring divider; the fixed margins use a
// reciprocal multiply on the same multiplier.
// ----------------------------------------------------------------------------
// channel | direction | handshake             | payload
// in_     | slave     | in_tvalid/in_tready   | in_tdata 72 b
// out_    | master    | out_tvalid/out_tready | out_tdata 24 b
// cfg_    | slave     | cfg_valid/cfg_ready   | cfg_index 3 b, cfg_data 31 b
//
// Each word runs two range jobs of operand, multiply, 33 divider steps and
// fixup, two margin jobs of operand, reciprocal multiply and fixup, then a
// timer check and the control step. in_tready is high only in idle; the
// result sits in an output register, and a stalled out_ holds the block in
// the last step. Synchronous active-low reset restores the register defaults.
// ----------------------------------------------------------------------------
module pneumatic_valve_setpoint_control_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [15:0] pressure_raw, [31:16] setpoint_user, [32] trigger_flag,
  // [64:33] now_ms, [71:65] zero
  input  logic [71:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [1:0] valve_command, [17:2] pressure_user, [18] inflating,
  // [19] deflating, [20] timed_out, [23:21] zero
  output logic [23:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data
);

  pvsc_pkg::state_t state_r, state_nxt;

  // configuration
  logic signed [15:0] min_p_r, max_p_r, safety_r, umin_r, umax_r;
  logic [30:0]        timeout_r;
  logic [14:0]        dmargin_r;

  // control state
  logic               ia_r, da_r;
  logic signed [15:0] lsp_r;
  logic [31:0]        ist_r, dst_r;
  logic [1:0]         valve_r;

  // latched input word
  logic signed [15:0] p_r, spu_r;
  logic               trig_r;
  logic [31:0]        now_r;

  // divider path
  logic [1:0]         op_r;
  logic signed [16:0] xa_r, dc_r, den_r, c_r;
  logic               neg_r, zero_r;
  logic [32:0]        dq_r;
  logic [16:0]        div_r, rem_r;
  logic [5:0]         cnt_r;
  logic signed [15:0] puser_r, sp_r, infm_r, refm_r;
  logic               inf_to_r, def_to_r;

  logic               out_valid_r;
  logic [23:0]        out_data_r;

  logic               in_fire, emit;

  // --- state machine ---
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pvsc_pkg::S_IDLE: if (in_fire) state_nxt = pvsc_pkg::S_OPND;
      pvsc_pkg::S_OPND: state_nxt = pvsc_pkg::S_MUL;
      pvsc_pkg::S_MUL: begin
        if (op_r inside {pvsc_pkg::OP_INFM, pvsc_pkg::OP_REFM})
          state_nxt = pvsc_pkg::S_FIN;
        else
          state_nxt = pvsc_pkg::S_DIV;
      end
      pvsc_pkg::S_DIV:  if (cnt_r == pvsc_pkg::DIV_LAST) state_nxt = pvsc_pkg::S_FIN;
      pvsc_pkg::S_FIN: begin
        if (op_r == pvsc_pkg::OP_REFM) state_nxt = pvsc_pkg::S_CHK;
        else                           state_nxt = pvsc_pkg::S_OPND;
      end
      pvsc_pkg::S_CHK:  state_nxt = pvsc_pkg::S_EVAL;
      pvsc_pkg::S_EVAL: if (emit) state_nxt = pvsc_pkg::S_IDLE;
      default:          state_nxt = pvsc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = (state_r == pvsc_pkg::S_IDLE);
    emit      = (state_r == pvsc_pkg::S_EVAL) && (!out_valid_r || out_tready);
  end

  assign in_fire    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= pvsc_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  // --- operand select ---
  logic signed [16:0] xa_nxt, dc_nxt, den_nxt, c_nxt;
  always_comb begin
    xa_nxt  = 17'(p_r) - 17'(min_p_r);
    dc_nxt  = 17'sd1;
    den_nxt = 17'sd1;
    c_nxt   = '0;
    case (op_r)
      pvsc_pkg::OP_PUSER: begin
        dc_nxt  = 17'(umax_r) - 17'(umin_r);
        den_nxt = 17'(max_p_r) - 17'(min_p_r);
        c_nxt   = 17'(umin_r);
      end
      pvsc_pkg::OP_SP: begin
        xa_nxt  = 17'(spu_r) - 17'(umin_r);
        dc_nxt  = 17'(max_p_r) - 17'(min_p_r);
        den_nxt = 17'(umax_r) - 17'(umin_r);
        c_nxt   = 17'(min_p_r);
      end
      pvsc_pkg::OP_INFM: dc_nxt = pvsc_pkg::RECIP_TEN;
      pvsc_pkg::OP_REFM: dc_nxt = pvsc_pkg::RECIP_TEN;
      default: ;
    endcase
  end

  // --- multiply, divide step, fixup ---
  logic signed [33:0] prod;
  logic [33:0]        prod_mag;
  logic [16:0]        den_mag;
  logic [17:0]        trial;
  logic signed [34:0] q_s, sum_s;
  logic signed [15:0] res;

  assign prod     = xa_r * dc_r;
  assign prod_mag = prod[33] ? 34'(-prod) : 34'(prod);
  assign den_mag  = den_r[16] ? 17'(-den_r) : 17'(den_r);
  assign trial    = {rem_r, dq_r[32]} - {1'b0, div_r};

  always_comb begin
    q_s   = neg_r ? -$signed({2'b00, dq_r}) : $signed({2'b00, dq_r});
    sum_s = q_s + 35'(c_r);
    if (zero_r)                    res = c_r[15:0];
    else if (sum_s > pvsc_pkg::SAT_HI) res = 16'sh7fff;
    else if (sum_s < pvsc_pkg::SAT_LO) res = -16'sh8000;
    else                           res = sum_s[15:0];
  end

  // --- control step ---
  logic signed [16:0] p17, sp17, inf_lim, def_lim, ref_lim;
  logic               ia_n, da_n, fired, ist_new, dst_new;
  logic signed [15:0] lsp_n;
  logic [31:0]        ist_n, dst_n;
  logic [1:0]         vs_n;

  always_comb begin
    p17     = 17'(p_r);
    sp17    = 17'(sp_r);
    inf_lim = sp17 - 17'(infm_r);
    def_lim = sp17 - $signed({2'b00, dmargin_r});
    ref_lim = sp17 - 17'(refm_r);
    vs_n    = (p_r > safety_r) ? pvsc_pkg::VALVE_OFF : valve_r;
    ia_n    = ia_r;
    da_n    = da_r;
    lsp_n   = lsp_r;
    ist_n   = ist_r;
    dst_n   = dst_r;
    ist_new = 1'b0;
    dst_new = 1'b0;
    fired   = 1'b0;
    if (lsp_r != sp_r && p_r < sp_r && trig_r) begin
      da_n    = 1'b0;
      vs_n    = pvsc_pkg::VALVE_INF;
      ia_n    = 1'b1;
      ist_n   = now_r;
      ist_new = 1'b1;
      lsp_n   = sp_r;
    end else if (p17 > inf_lim && ia_r) begin
      vs_n = pvsc_pkg::VALVE_OFF;
      ia_n = 1'b0;
    end else if (lsp_r != sp_r && p_r > sp_r && trig_r) begin
      ia_n    = 1'b0;
      vs_n    = pvsc_pkg::VALVE_DEF;
      da_n    = 1'b1;
      dst_n   = now_r;
      dst_new = 1'b1;
      lsp_n   = sp_r;
    end else if (p17 < def_lim && da_r) begin
      if (sp_r != 16'sd0) vs_n = pvsc_pkg::VALVE_OFF;
      da_n = 1'b0;
    end
    // a timer started in this step has zero elapsed time
    if (ia_n && inf_to_r && !ist_new) begin
      ia_n  = 1'b0;
      vs_n  = pvsc_pkg::VALVE_OFF;
      fired = 1'b1;
    end
    if (da_n && def_to_r && !dst_new) begin
      da_n  = 1'b0;
      vs_n  = pvsc_pkg::VALVE_OFF;
      fired = 1'b1;
    end
    if (!ia_n && !da_n && p17 < ref_lim && !trig_r) begin
      vs_n  = pvsc_pkg::VALVE_INF;
      ia_n  = 1'b1;
      ist_n = now_r;
    end
  end

  // --- registers ---
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_p_r     <= 16'sd0;
      max_p_r     <= 16'sd32767;
      safety_r    <= 16'sd32767;
      timeout_r   <= 31'd5000;
      dmargin_r   <= 15'd500;
      umin_r      <= 16'sd0;
      umax_r      <= 16'sd100;
      ia_r        <= 1'b0;
      da_r        <= 1'b0;
      lsp_r       <= 16'sd0;
      ist_r       <= '0;
      dst_r       <= '0;
      valve_r     <= pvsc_pkg::VALVE_OFF;
      out_valid_r <= 1'b0;
      op_r        <= pvsc_pkg::OP_PUSER;
      cnt_r       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pvsc_pkg::REG_MIN_P:    min_p_r   <= cfg_data[15:0];
          pvsc_pkg::REG_MAX_P:    max_p_r   <= cfg_data[15:0];
          pvsc_pkg::REG_SAFETY:   safety_r  <= cfg_data[15:0];
          pvsc_pkg::REG_TIMEOUT:  timeout_r <= cfg_data;
          pvsc_pkg::REG_DMARGIN:  dmargin_r <= cfg_data[14:0];
          pvsc_pkg::REG_USER_MIN: umin_r    <= cfg_data[15:0];
          pvsc_pkg::REG_USER_MAX: umax_r    <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (emit)                           out_valid_r <= 1'b1;
      else if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      case (state_r)
        pvsc_pkg::S_IDLE: op_r <= pvsc_pkg::OP_PUSER;
        pvsc_pkg::S_MUL:  cnt_r <= '0;
        pvsc_pkg::S_DIV:  cnt_r <= cnt_r + 6'd1;
        pvsc_pkg::S_FIN:  op_r <= op_r + 2'd1;
        pvsc_pkg::S_EVAL: begin
          if (emit) begin
            ia_r        <= ia_n;
            da_r        <= da_n;
            lsp_r       <= lsp_n;
            ist_r       <= ist_n;
            dst_r       <= dst_n;
            valve_r     <= vs_n;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      p_r    <= in_tdata[15:0];
      spu_r  <= in_tdata[31:16];
      trig_r <= in_tdata[32];
      now_r  <= in_tdata[64:33];
    end
    case (state_r)
      pvsc_pkg::S_OPND: begin
        xa_r  <= xa_nxt;
        dc_r  <= dc_nxt;
        den_r <= den_nxt;
        c_r   <= c_nxt;
      end
      pvsc_pkg::S_MUL: begin
        neg_r  <= prod[33] ^ den_r[16];
        zero_r <= (den_r == 17'sd0);
        case (op_r)
          pvsc_pkg::OP_INFM: dq_r <= 33'(prod_mag >> pvsc_pkg::INF_SHIFT);
          pvsc_pkg::OP_REFM: dq_r <= 33'(prod_mag >> pvsc_pkg::REFILL_SHIFT);
          default:           dq_r <= prod_mag[32:0];
        endcase
        div_r  <= den_mag;
        rem_r  <= '0;
      end
      pvsc_pkg::S_DIV: begin
        if (!trial[17]) begin
          rem_r <= trial[16:0];
          dq_r  <= {dq_r[31:0], 1'b1};
        end else begin
          rem_r <= {rem_r[15:0], dq_r[32]};
          dq_r  <= {dq_r[31:0], 1'b0};
        end
      end
      pvsc_pkg::S_FIN: begin
        case (op_r)
          pvsc_pkg::OP_PUSER: puser_r <= res;
          pvsc_pkg::OP_SP:    sp_r    <= res;
          pvsc_pkg::OP_INFM:  infm_r  <= res;
          pvsc_pkg::OP_REFM:  refm_r  <= res;
          default: ;
        endcase
      end
      pvsc_pkg::S_CHK: begin
        inf_to_r <= (now_r - ist_r) > {1'b0, timeout_r};
        def_to_r <= (now_r - dst_r) > {1'b0, timeout_r};
      end
      pvsc_pkg::S_EVAL: begin
        if (emit) out_data_r <= {3'b000, fired, da_n, ia_n, puser_r, vs_n};
      end
      default: ;
    endcase
  end

endmodule

/* test/pneumatic_valve_setpoint_control_core_test.sv */
// ----------------------------------------------------------------------------
// pneumatic_valve_setpoint_control_core_test
// Self-checking bench for the valve setpoint control core. A directed table of
// words and register writes runs first. Random setpoint sequences follow under
// several register settings: a trigger word with pressure ramping toward the
// setpoint, then time jumps across the timeout and noise words. Each result
// word is checked per field against a typed row or an in-bench control model.
// ----------------------------------------------------------------------------
module pneumatic_valve_setpoint_control_core_test;

  typedef struct packed {
    logic [1:0]         valve;
    logic signed [15:0] puser;
    logic               infl;
    logic               defl;
    logic               fired;
  } result_t;

  typedef struct packed {
    logic               is_cfg;
    logic [2:0]         idx;
    logic [30:0]        cdata;
    logic signed [15:0] p;
    logic signed [15:0] spu;
    logic               trig;
    logic [31:0]        now;
    logic               known;
    result_t            res;
  } row_t;

  localparam int NUM_ROWS = 26;
  localparam int NUM_PHASES = 8;
  localparam int PHASE_WORDS = 232;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [30:0] cfg_data = '0;

  // model registers
  logic signed [15:0] cfg_min_p = 16'sd0;
  logic signed [15:0] cfg_max_p = 16'sd32767;
  logic signed [15:0] cfg_safety = 16'sd32767;
  logic [30:0]        cfg_timeout = 31'd5000;
  logic [14:0]        cfg_dmargin = 15'd500;
  logic signed [15:0] cfg_umin = 16'sd0;
  logic signed [15:0] cfg_umax = 16'sd100;

  // model state
  logic        inf_on = 1'b0;
  logic        def_on = 1'b0;
  int          sp_last = 0;
  logic [31:0] inf_t0 = '0;
  logic [31:0] def_t0 = '0;
  logic [1:0]  valve = pvsc_pkg::VALVE_OFF;

  result_t pending_steps[$];
  int      errors = 0;
  int      words_sent = 0;
  int      words_checked = 0;
  int      settings_used = 1;
  int      stall_left = 0;
  logic    calm = 1'b0;
  logic [31:0] tick;

  row_t dir_rows [0:NUM_ROWS-1] = '{
    '{1'b0, pvsc_pkg::REG_MIN_P, 31'd0, 16'sd0, 16'sd0, 1'b0, 32'd0, 1'b1,
      '{pvsc_pkg::VALVE_OFF, 16'sd0, 1'b0, 1'b0, 1'b0}},
    '{1'b0, pvsc_pkg::REG_MIN_P, 31'd0, 16'sd32767, 16'sd100, 1'b1, 32'd5, 1'b1,
      '{pvsc_pkg::VALVE_OFF, 16'sd100, 1'b0, 1'b0, 1'b0}},
    '{1'b0, pvsc_pkg::REG_MIN_P, 31'd0, -16'sd32768, -16'sd32768, 1'b1, 32'd10, 1'b1,
      '{pvsc_pkg::VALVE_OFF, -16'sd100, 1'b0, 1'b0, 1'b0}},
    // inflate start, hold, early end
    '{1'b0, pvsc_pkg::REG_MIN_P, 31'd0, 16'sd1000, 16'sd50, 1'b1, 32'd20, 1'b0, '0},
    '{1'b0, pvsc_pkg::REG_MIN_P, 31'd0, 16'sd5000, 16'sd50, 1'b0, 32'd40, 1'b0, '0},
    '{1'b0, pvsc_pkg::REG_MIN_P, 31'd0, 16'sd16000, 16'sd50, 1'b0, 32'd60, 1'b0, '0},
    // deflate start and end
    '{1'b0, pvsc_pkg::REG_MIN_P, 31'd0, 16'sd30000, 16'sd20, 1'b1, 32'd80, 1'b0, '0},
    '{1'b0, pvsc_pkg::REG_MIN_P, 31'd0, 16'sd5000, 16'sd20, 1'b0, 32'd100, 1'b0, '0},
    // inflate timeout
    '{1'b0, pvsc_pkg::REG_MIN_P, 31'd0, 16'sd0, 16'sd80, 1'b1, 32'd200, 1'b0, '0},
    '{1'b0, pvsc_pkg::REG_MIN_P, 31'd0, 16'sd100, 16'sd80, 1'b0, 32'd5201, 1'b0, '0},
    // deflate timeout
    '{1'b0, pvsc_pkg::REG_MIN_P, 31'd0, 16'sd32000, 16'sd10, 1'b1, 32'd6000, 1'b0, '0},
    '{1'b0, pvsc_pkg::REG_MIN_P, 31'd0, 16'sd31000, 16'sd10, 1'b0, 32'd11001, 1'b0, '0},
    // refill
    '{1'b0, pvsc_pkg::REG_MIN_P, 31'd0, 16'sd1000, 16'sd30, 1'b0, 32'd11100, 1'b0, '0},
    // zero setpoint: deflate end does not close the valve, then refill starts inflate
    '{1'b0, pvsc_pkg::REG_MIN_P, 31'd0, 16'sd20000, 16'sd0, 1'b1, 32'd11200, 1'b0, '0},
    '{1'b0, pvsc_pkg::REG_MIN_P, 31'd0, 16'sd20000, 16'sd0, 1'b1, 32'd11300, 1'b0, '0},
    '{1'b0, pvsc_pkg::REG_MIN_P, 31'd0, -16'sd2000, 16'sd0, 1'b0, 32'd11400, 1'b0, '0},
    // time wraps during inflate
    '{1'b0, pvsc_pkg::REG_MIN_P, 31'd0, 16'sd100, 16'sd60, 1'b1, 32'hFFFF_FFF0, 1'b0, '0},
    '{1'b0, pvsc_pkg::REG_MIN_P, 31'd0, 16'sd200, 16'sd60, 1'b0, 32'h0000_0010, 1'b0, '0},
    // safety stop, then reopen in the same step
    '{1'b1, pvsc_pkg::REG_SAFETY, 31'd1000, 16'sd0, 16'sd0, 1'b0, 32'd0, 1'b0, '0},
    '{1'b0, pvsc_pkg::REG_MIN_P, 31'd0, 16'sd2000, 16'sd90, 1'b1, 32'd100, 1'b0, '0},
    '{1'b0, pvsc_pkg::REG_MIN_P, 31'd0, 16'sd2000, 16'sd90, 1'b0, 32'd120, 1'b0, '0},
    // empty raw range
    '{1'b1, pvsc_pkg::REG_MIN_P, 31'd5, 16'sd0, 16'sd0, 1'b0, 32'd0, 1'b0, '0},
    '{1'b1, pvsc_pkg::REG_MAX_P, 31'd5, 16'sd0, 16'sd0, 1'b0, 32'd0, 1'b0, '0},
    '{1'b0, pvsc_pkg::REG_MIN_P, 31'd0, 16'sd7, 16'sd3, 1'b1, 32'd200, 1'b0, '0},
    '{1'b0, pvsc_pkg::REG_MIN_P, 31'd0, 16'sd2, 16'sd3, 1'b0, 32'd220, 1'b0, '0},
    '{1'b0, pvsc_pkg::REG_MIN_P, 31'd0, -16'sd32768, 16'sd32767, 1'b1, 32'd240, 1'b0, '0}
  };

  // min_p, max_p, safety, timeout, dmargin, user_min, user_max
  int phase_cfg [0:NUM_PHASES-1][0:6] = '{
    '{-32768, 32767, 32767, 2147483647, 0, -32768, 32767},
    '{1000, 20000, 15000, 300, 32767, 0, 100},
    '{20000, -5000, 10000, 50, 200, -100, 100},
    '{500, 500, -32768, 5000, 500, 0, 100},
    '{0, 30000, 25000, 0, 100, 50, 50},
    '{0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0, 0, 0},
    '{0, 32767, 32767, 2000, 500, 0, 1000}
  };

  pneumatic_valve_setpoint_control_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("%0t timeout, %0d words still pending", $time, pending_steps.size());
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  function automatic int lin_map(int x, int a, int b, int c, int d);
    longint den;
    den = longint'(b) - longint'(a);
    if (den == 0) return sat16(c);
    return sat16((longint'(x) - a) * (longint'(d) - c) / den + c);
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [30:0] data);
    case (idx)
      pvsc_pkg::REG_MIN_P:    cfg_min_p = data[15:0];
      pvsc_pkg::REG_MAX_P:    cfg_max_p = data[15:0];
      pvsc_pkg::REG_SAFETY:   cfg_safety = data[15:0];
      pvsc_pkg::REG_TIMEOUT:  cfg_timeout = data;
      pvsc_pkg::REG_DMARGIN:  cfg_dmargin = data[14:0];
      pvsc_pkg::REG_USER_MIN: cfg_umin = data[15:0];
      pvsc_pkg::REG_USER_MAX: cfg_umax = data[15:0];
      default: ;
    endcase
  endfunction

  // one bang-bang step with hysteresis, timeouts and refill
  function automatic result_t control_step(logic signed [15:0] p16, logic signed [15:0] spu,
                                           logic trig, logic [31:0] now);
    int      p;
    int      sp;
    int      inf_m;
    int      ref_m;
    logic    fired;
    result_t r;
    p = p16;
    fired = 1'b0;
    if (p > cfg_safety) valve = pvsc_pkg::VALVE_OFF;
    r.puser = 16'(lin_map(p, cfg_min_p, cfg_max_p, cfg_umin, cfg_umax));
    sp = lin_map(spu, cfg_umin, cfg_umax, cfg_min_p, cfg_max_p);
    inf_m = (p - int'(cfg_min_p)) / 20;
    ref_m = (p - int'(cfg_min_p)) / 10;
    if (sp_last != sp && p < sp && trig) begin
      def_on = 1'b0;
      valve = pvsc_pkg::VALVE_INF;
      inf_on = 1'b1;
      inf_t0 = now;
      sp_last = sp;
    end else if (p > sp - inf_m && inf_on) begin
      valve = pvsc_pkg::VALVE_OFF;
      inf_on = 1'b0;
    end else if (sp_last != sp && p > sp && trig) begin
      inf_on = 1'b0;
      valve = pvsc_pkg::VALVE_DEF;
      def_on = 1'b1;
      def_t0 = now;
      sp_last = sp;
    end else if (p < sp - int'(cfg_dmargin) && def_on) begin
      if (sp != 0) valve = pvsc_pkg::VALVE_OFF;
      def_on = 1'b0;
    end
    if (inf_on && (now - inf_t0) > {1'b0, cfg_timeout}) begin
      inf_on = 1'b0;
      valve = pvsc_pkg::VALVE_OFF;
      fired = 1'b1;
    end
    if (def_on && (now - def_t0) > {1'b0, cfg_timeout}) begin
      def_on = 1'b0;
      valve = pvsc_pkg::VALVE_OFF;
      fired = 1'b1;
    end
    if (!inf_on && !def_on && p < sp - ref_m && !trig) begin
      valve = pvsc_pkg::VALVE_INF;
      inf_on = 1'b1;
      inf_t0 = now;
    end
    r.valve = valve;
    r.infl = inf_on;
    r.defl = def_on;
    r.fired = fired;
    return r;
  endfunction

  task automatic send_word(logic signed [15:0] p, logic signed [15:0] spu, logic trig,
                           logic [31:0] now, logic known, result_t typed);
    result_t want;
    int      gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 5);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {7'd0, now, trig, spu, p};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    want = control_step(p, spu, trig, now);
    pending_steps.push_back(known ? typed : want);
    words_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_steps.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [30:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_setting(int ph);
    logic [30:0] junk;
    logic [2:0]  idx;
    int          v;
    for (int i = 0; i < 7; i++) begin
      idx = 3'(i);
      v = phase_cfg[ph][i];
      if (ph == 5 || ph == 6) begin
        case (idx)
          pvsc_pkg::REG_TIMEOUT:
            v = (ph == 5) ? $urandom_range(0, 4000) : $urandom_range(0, 300);
          pvsc_pkg::REG_DMARGIN: v = $urandom_range(0, 32767);
          default:               v = $signed(16'($urandom));
        endcase
      end
      junk = 31'($urandom);
      case (idx)
        pvsc_pkg::REG_TIMEOUT: junk = 31'(v);
        pvsc_pkg::REG_DMARGIN: junk[14:0] = 15'(v);
        default:               junk[15:0] = 16'(v);
      endcase
      write_reg(idx, junk);
    end
  endtask

  // trigger a setpoint, then let pressure drift toward it
  task automatic run_sequence();
    logic signed [15:0] spu;
    logic               trig;
    int lo, hi, off, sp_r, p, steps, dt, step_div, noise;
    lo = (cfg_umin < cfg_umax) ? cfg_umin : cfg_umax;
    hi = (cfg_umin < cfg_umax) ? cfg_umax : cfg_umin;
    if ($urandom_range(0, 3) == 0) spu = 16'($urandom);
    else begin
      off = $urandom_range(0, hi - lo);
      spu = 16'(lo + off);
    end
    sp_r = lin_map(spu, cfg_umin, cfg_umax, cfg_min_p, cfg_max_p);
    off = $urandom_range(0, 3000);
    case ($urandom_range(0, 2))
      0:       p = sat16(sp_r - off);
      1:       p = sat16(sp_r + off);
      default: p = $signed(16'($urandom));
    endcase
    tick = tick + $urandom_range(1, 60);
    send_word(16'(p), spu, 1'b1, tick, 1'b0, '0);
    steps = $urandom_range(2, 12);
    repeat (steps) begin
      if ($urandom_range(0, 11) == 0) dt = int'(cfg_timeout) + $urandom_range(0, 1);
      else dt = $urandom_range(1, 60);
      tick = tick + 32'(dt);
      if ($urandom_range(0, 7) == 0) p = $signed(16'($urandom));
      else begin
        step_div = $urandom_range(1, 4);
        noise = $urandom_range(0, 300);
        p = sat16(longint'(p) + (longint'(sp_r) - p) / step_div + noise - 150);
      end
      trig = ($urandom_range(0, 7) == 0);
      send_word(16'(p), spu, trig, tick, 1'b0, '0);
    end
  endtask

  task automatic report(string field, int want, int got);
    $display("%0t mismatch %s: expected %0d, got %0d", $time, field, want, got);
    errors++;
  endtask

  always @(negedge clk) begin
    if (!calm && stall_left == 0 && $urandom_range(0, 7) == 0)
      stall_left = $urandom_range(1, 5);
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.valve = out_tdata[1:0];
      got.puser = out_tdata[17:2];
      got.infl  = out_tdata[18];
      got.defl  = out_tdata[19];
      got.fired = out_tdata[20];
      if (pending_steps.size() == 0) begin
        $display("%0t unexpected word %h", $time, out_tdata);
        errors++;
      end else begin
        want = pending_steps.pop_front();
        words_checked++;
        if (got.valve !== want.valve) report("valve_command", want.valve, got.valve);
        if (got.puser !== want.puser) report("pressure_user", want.puser, got.puser);
        if (got.infl !== want.infl) report("inflating", want.infl, got.infl);
        if (got.defl !== want.defl) report("deflating", want.defl, got.defl);
        if (got.fired !== want.fired) report("timed_out", want.fired, got.fired);
        if (out_tdata[23:21] !== 3'd0) report("pad bits", 0, out_tdata[23:21]);
      end
    end
  end

  initial begin
    int target;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_ROWS; i++) begin
      if (dir_rows[i].is_cfg) begin
        drain();
        write_reg(dir_rows[i].idx, dir_rows[i].cdata);
        settings_used++;
      end else begin
        send_word(dir_rows[i].p, dir_rows[i].spu, dir_rows[i].trig, dir_rows[i].now,
                  dir_rows[i].known, dir_rows[i].res);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      calm = (ph == NUM_PHASES - 1);
      load_setting(ph);
      settings_used++;
      tick = $urandom;
      target = words_sent + PHASE_WORDS;
      while (words_sent < target) begin
        if (ph != NUM_PHASES - 1) calm = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 7) == 0)
          send_word(16'($urandom), 16'($urandom), 1'($urandom), $urandom, 1'b0, '0);
        else
          run_sequence();
      end
    end

    drain();
    repeat (200) @(posedge clk);
    $display("%0d words checked, %0d errors, across %0d register settings", words_checked,
             errors, settings_used);
    $display("covered inflate, deflate, timeouts, refill, safety stop and empty ranges");
    if (errors == 0 && pending_steps.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
